// File: rtl/salc_pkg.sv
package salc_pkg;

  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int SETS         = 1 << MAX_SET_BITS;
  localparam int WAY_W        = $clog2(MAX_WAYS);
  localparam int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int ADDR_W       = 32;
  localparam int CNT_W        = 32;
  localparam int PADDR_W      = 4;

  // configuration register indexes (byte address is 4 * index)
  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_WAYS       = 2'd1;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

  // command codes
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_STORE  = 2'd1;
  localparam logic [1:0] CMD_MODIFY = 2'd2;

  // outcome building blocks
  localparam logic [2:0] OUT_MISS      = 3'd0;
  localparam logic [2:0] OUT_HIT       = 3'd1;
  localparam logic [2:0] OUT_EVICT     = 3'd2;
  localparam logic [2:0] OUT_MODIFY    = 3'd3;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [2:0]       outcome;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
    logic [CNT_W-1:0] eviction_count;
  } rsp_t;

  typedef struct packed {
    logic [MAX_WAYS-1:0]                valid;
    logic [MAX_WAYS-1:0][ADDR_W-1:0]    tag;
    logic [MAX_WAYS-1:0][CNT_W-1:0]     stamp;
  } row_t;

endpackage

// File: rtl/set_assoc_lru_cache_model_core.sv
// set-associative cache model with lru replacement, one set row per memory entry
// the set row is read into a register at request accept; lookup and write back follow in the
// lookup state, which loads the result register; a new request is taken only once the
// read-modify-write of the set row memory is done, and a held result stalls the lookup cycle until it is taken
// reset (rst, synchronous): counters, use clock and row-written flags clear, config to 0/1/0;
// no clearing pass: a set row never written since reset reads as all ways invalid
module set_assoc_lru_cache_model_core
  import salc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  req_t               req,
  input  logic               req_valid,
  output logic               req_ready,
  // result channel
  output rsp_t               rsp,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_t;

  state_t state, state_next;

  // configuration registers, kept raw; clamping happens on use
  logic [2:0] set_bits;
  logic [3:0] ways;
  logic [4:0] block_bits;

  // running totals and use clock
  logic [CNT_W-1:0] use_clock;
  logic [CNT_W-1:0] hits_total;
  logic [CNT_W-1:0] misses_total;
  logic [CNT_W-1:0] evictions_total;

  // set row memory plus one written-since-reset flag per row
  row_t          mem [SETS];
  logic [SETS-1:0] row_init;
  row_t          rd_row;
  logic          init_q;

  // request held for the lookup cycle
  logic [1:0]        cmd_q;
  logic [SET_W-1:0]  set_q;
  logic [ADDR_W-1:0] tag_q;

  logic       req_fire;
  logic       finish;
  logic [2:0] sb_eff;
  logic [3:0] nw_eff;
  logic [5:0] split_sum;
  logic [ADDR_W-1:0] addr_shift;
  logic [SET_W-1:0]  set_in;
  logic [ADDR_W-1:0] tag_in;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits   <= 3'd0;
      ways       <= 4'd1;
      block_bits <= 5'd0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_SET_BITS:   set_bits   <= pwdata[2:0];
        REG_WAYS:       ways       <= pwdata[3:0];
        REG_BLOCK_BITS: block_bits <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SET_BITS:   prdata = {29'd0, set_bits};
      REG_WAYS:       prdata = {28'd0, ways};
      REG_BLOCK_BITS: prdata = {27'd0, block_bits};
      default:        prdata = 32'd0;
    endcase
  end

  // effective geometry: set bits clamp to the max, ways clamp into 1..max
  assign sb_eff = (set_bits > 3'(MAX_SET_BITS)) ? 3'(MAX_SET_BITS) : set_bits;
  always_comb begin
    if (ways == 4'd0) begin
      nw_eff = 4'd1;
    end else if (ways > 4'(MAX_WAYS)) begin
      nw_eff = 4'(MAX_WAYS);
    end else begin
      nw_eff = ways;
    end
  end

  // ---------------------------------------------------------------------------
  // address split at accept time
  // ---------------------------------------------------------------------------
  assign split_sum  = {3'd0, sb_eff} + {1'b0, block_bits};
  assign addr_shift = req.address >> block_bits;
  assign set_in     = addr_shift[SET_W-1:0] & SET_W'((SET_W'(1) << sb_eff) - SET_W'(1));
  // no tag bits left once the split covers the whole address
  assign tag_in     = (split_sum >= 6'd32) ? '0 : (req.address >> split_sum[4:0]);

  // ---------------------------------------------------------------------------
  // handshake and sequencing: accept in idle, then look up and write back in the lookup cycle
  // ---------------------------------------------------------------------------
  assign req_ready = (state == ST_IDLE);
  assign req_fire  = req_valid && req_ready;
  // the lookup cycle completes only when the result register can take the result
  assign finish    = (state == ST_LOOK) && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (req_fire) state_next = ST_LOOK;
      ST_LOOK: if (finish)   state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request capture and set row read
  always_ff @(posedge clk) begin
    if (req_fire) begin
      cmd_q  <= req.command;
      set_q  <= set_in;
      tag_q  <= tag_in;
      rd_row <= mem[set_in];
      init_q <= row_init[set_in];
    end
  end

  // ---------------------------------------------------------------------------
  // lookup on the row just read
  // ---------------------------------------------------------------------------
  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] valid_eff;
  logic                hit;
  logic [WAY_W-1:0]    hit_way;
  logic                free_found;
  logic [WAY_W-1:0]    free_way;
  logic                set_full;
  logic [CNT_W-1:0]    stamp_new;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w]    = (4'(w) < nw_eff);
      // a row never written since reset has no valid ways
      valid_eff[w] = init_q && rd_row.valid[w] && in_use[w];
    end
  end

  // lowest matching way wins; lowest free way is filled first
  always_comb begin
    hit        = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!hit && valid_eff[w] && (rd_row.tag[w] == tag_q)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!free_found && in_use[w] && !valid_eff[w]) begin
        free_found = 1'b1;
        free_way   = WAY_W'(w);
      end
    end
  end

  assign set_full  = !free_found;
  assign stamp_new = use_clock + CNT_W'(1);

  // lru victim: pairwise tree over the ways in use, ties go to the lower way
  logic             c1 [4];
  logic [CNT_W-1:0] s1 [4];
  logic [WAY_W-1:0] i1 [4];
  logic             c2 [2];
  logic [CNT_W-1:0] s2 [2];
  logic [WAY_W-1:0] i2 [2];
  logic [WAY_W-1:0] lru_way;

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      if (in_use[2*p+1] && (!in_use[2*p] || (rd_row.stamp[2*p+1] < rd_row.stamp[2*p]))) begin
        c1[p] = 1'b1;
        s1[p] = rd_row.stamp[2*p+1];
        i1[p] = WAY_W'(2*p+1);
      end else begin
        c1[p] = in_use[2*p];
        s1[p] = rd_row.stamp[2*p];
        i1[p] = WAY_W'(2*p);
      end
    end
    for (int p = 0; p < 2; p++) begin
      if (c1[2*p+1] && (!c1[2*p] || (s1[2*p+1] < s1[2*p]))) begin
        c2[p] = 1'b1;
        s2[p] = s1[2*p+1];
        i2[p] = i1[2*p+1];
      end else begin
        c2[p] = c1[2*p];
        s2[p] = s1[2*p];
        i2[p] = i1[2*p];
      end
    end
    if (c2[1] && (!c2[0] || (s2[1] < s2[0]))) begin
      lru_way = i2[1];
    end else begin
      lru_way = i2[0];
    end
  end

  // ---------------------------------------------------------------------------
  // write back: stamp the hit way, or fill the free / lru way
  // ---------------------------------------------------------------------------
  row_t             wr_row;
  logic [WAY_W-1:0] victim;
  logic             is_modify;
  logic             evict;
  logic [2:0]       outcome;

  assign victim    = free_found ? free_way : lru_way;
  assign is_modify = (cmd_q == CMD_MODIFY);
  assign evict     = !hit && set_full;

  always_comb begin
    wr_row = rd_row;
    // stale valid bits of a never-written row must not survive
    if (!init_q) begin
      wr_row.valid = '0;
    end
    if (hit) begin
      wr_row.stamp[hit_way] = stamp_new;
    end else begin
      wr_row.valid[victim] = 1'b1;
      wr_row.tag[victim]   = tag_q;
      wr_row.stamp[victim] = stamp_new;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      mem[set_q] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_init <= '0;
    end else if (finish) begin
      row_init[set_q] <= 1'b1;
    end
  end

  // outcome code: hit / evict flags, plus the modify offset
  always_comb begin
    outcome = OUT_MISS;
    if (hit) begin
      outcome = OUT_HIT;
    end else if (evict) begin
      outcome = OUT_EVICT;
    end
    if (is_modify) begin
      outcome = outcome + OUT_MODIFY;
    end
  end

  // ---------------------------------------------------------------------------
  // totals and result register
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] hits_next;
  logic [CNT_W-1:0] misses_next;
  logic [CNT_W-1:0] evictions_next;

  // a modify always scores one extra hit for its store half
  assign hits_next      = hits_total + CNT_W'(hit) + CNT_W'(is_modify);
  assign misses_next    = misses_total + CNT_W'(!hit);
  assign evictions_next = evictions_total + CNT_W'(evict);

  always_ff @(posedge clk) begin
    if (rst) begin
      use_clock       <= '0;
      hits_total      <= '0;
      misses_total    <= '0;
      evictions_total <= '0;
    end else if (finish) begin
      use_clock       <= stamp_new;
      hits_total      <= hits_next;
      misses_total    <= misses_next;
      evictions_total <= evictions_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp.outcome        <= outcome;
      rsp.hit_count      <= hits_next;
      rsp.miss_count     <= misses_next;
      rsp.eviction_count <= evictions_next;
    end
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

import salc_pkg::*;

// predicted cache state and the results it implies, in acceptance order
class cache_scoreboard;
  bit          line_valid[SETS*MAX_WAYS];
  logic [31:0] line_tag[SETS*MAX_WAYS];
  logic [31:0] line_stamp[SETS*MAX_WAYS];
  logic [31:0] use_clock;
  logic [31:0] hits;
  logic [31:0] misses;
  logic [31:0] evictions;
  logic [2:0]  set_bits;
  logic [3:0]  ways;
  logic [4:0]  block_bits;
  rsp_t        expected_q[$];
  int          failures;

  function new();
    foreach (line_valid[e]) line_valid[e] = 1'b0;
    use_clock  = '0;
    hits       = '0;
    misses     = '0;
    evictions  = '0;
    set_bits   = 3'd0;
    ways       = 4'd1;
    block_bits = 5'd0;
    failures   = 0;
  endfunction

  function void set_register(logic [1:0] index, logic [31:0] value);
    case (index)
      REG_SET_BITS:   set_bits   = value[2:0];
      REG_WAYS:       ways       = value[3:0];
      REG_BLOCK_BITS: block_bits = value[4:0];
      default: ;
    endcase
  endfunction

  // look up one request, update the lines and queue the result it yields
  function void note_request(req_t r);
    int          sb_used;
    int          nw;
    int          bb;
    int          base;
    int          valid_count;
    int          victim;
    bit          hit;
    bit          evict;
    bit          found_free;
    logic [31:0] set_idx;
    logic [31:0] tag;
    logic [2:0]  oc;
    rsp_t        want;
    sb_used = (set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(set_bits);
    nw = (ways == 0) ? 1 : ((ways > MAX_WAYS) ? MAX_WAYS : int'(ways));
    bb = int'(block_bits);
    set_idx = (r.address >> bb) & ((32'd1 << sb_used) - 32'd1);
    tag = (sb_used + bb >= 32) ? 32'd0 : (r.address >> (sb_used + bb));
    base = int'(set_idx) * MAX_WAYS;
    valid_count = 0;
    hit = 1'b0;
    evict = 1'b0;
    use_clock = use_clock + 32'd1;
    // lowest matching way wins when a split change leaves duplicates
    for (int w = 0; w < nw; w++) begin
      if (line_valid[base+w]) begin
        valid_count++;
        if (!hit && line_tag[base+w] == tag) begin
          hit = 1'b1;
          line_stamp[base+w] = use_clock;
        end
      end
    end
    if (hit) begin
      hits = hits + 32'd1;
    end else begin
      misses = misses + 32'd1;
      victim = 0;
      found_free = 1'b0;
      for (int w = 0; w < nw && !found_free; w++) begin
        if (!line_valid[base+w]) begin
          victim = w;
          found_free = 1'b1;
        end
      end
      if (!found_free) begin
        for (int w = 1; w < nw; w++) begin
          if (line_stamp[base+w] < line_stamp[base+victim]) victim = w;
        end
      end
      line_valid[base+victim] = 1'b1;
      line_tag[base+victim]   = tag;
      line_stamp[base+victim] = use_clock;
      if (valid_count == nw) begin
        evict = 1'b1;
        evictions = evictions + 32'd1;
      end
    end
    oc = hit ? OUT_HIT : OUT_MISS;
    if (evict) oc = oc + OUT_EVICT;
    if (r.command == CMD_MODIFY) begin
      hits = hits + 32'd1;
      oc = oc + OUT_MODIFY;
    end
    want.outcome        = oc;
    want.hit_count      = hits;
    want.miss_count     = misses;
    want.eviction_count = evictions;
    expected_q.push_back(want);
  endfunction

  function void check_result(rsp_t got);
    rsp_t want;
    if (expected_q.size() == 0) begin
      $display("%0t unexpected result: outcome %0d hits %0d misses %0d evictions %0d",
               $time, got.outcome, got.hit_count, got.miss_count, got.eviction_count);
      failures++;
      return;
    end
    want = expected_q.pop_front();
    if (got.outcome !== want.outcome) begin
      $display("%0t outcome mismatch: expected %0d, actual %0d",
               $time, want.outcome, got.outcome);
      failures++;
    end
    if (got.hit_count !== want.hit_count) begin
      $display("%0t hit_count mismatch: expected %0d, actual %0d",
               $time, want.hit_count, got.hit_count);
      failures++;
    end
    if (got.miss_count !== want.miss_count) begin
      $display("%0t miss_count mismatch: expected %0d, actual %0d",
               $time, want.miss_count, got.miss_count);
      failures++;
    end
    if (got.eviction_count !== want.eviction_count) begin
      $display("%0t eviction_count mismatch: expected %0d, actual %0d",
               $time, want.eviction_count, got.eviction_count);
      failures++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb;

  // command 3 has no name in the package; the cache treats it as a load
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  // cycles with no handshake of any kind before the run is declared hung
  localparam int QUIET_LIMIT = 5000;
  // length of the one long result back-pressure window
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int HOLD_OFF_AT = 700;

  logic               clk;
  logic               rst;
  req_t               req;
  logic               req_valid;
  logic               req_ready;
  rsp_t               rsp;
  logic               rsp_valid;
  logic               rsp_ready;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  cache_scoreboard sb;
  int              results_seen;
  int              quiet_cycles;
  bit              no_idle;
  bit              held_off;

  set_assoc_lru_cache_model_core DUT (.*);

  // 2 ns clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // result side: random stalls, one long hold-off so the pipeline backs up
  initial begin
    rsp_ready = 1'b0;
    held_off = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && results_seen >= HOLD_OFF_AT) begin
        held_off = 1'b1;
        rsp_ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      rsp_ready = no_idle || ($urandom_range(0, 99) >= 11);
    end
  end

  // compare every accepted result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      sb.check_result(rsp);
      results_seen++;
    end
  end

  // hang detection: count cycles in which nothing moves on any port
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // offer one request, with an occasional idle gap in front of it
  task automatic send_request(input logic [1:0] cmd, input logic [31:0] addr);
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 99) < 11) begin
      req_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    req.command = cmd;
    req.address = addr;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    sb.note_request(req);
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic finish_requests();
    @(negedge clk);
    req_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // two-phase register write, only done while the cache is idle
  task automatic write_register(input logic [1:0] index, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = PADDR_W'({index, 2'b00});
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(index, value);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_split(input int set_val, input int ways_val, input int block_val);
    write_register(REG_SET_BITS, set_val);
    write_register(REG_WAYS, ways_val);
    write_register(REG_BLOCK_BITS, block_val);
  endtask

  // hand-picked corners: hits, evictions, modify, odd commands, clamping
  task automatic run_directed();
    // reset split: one set, one way, no offset
    send_request(CMD_LOAD, 32'h0000_0000);
    send_request(CMD_LOAD, 32'h0000_0000);
    send_request(CMD_STORE, 32'hFFFF_FFFF);
    send_request(CMD_MODIFY, 32'hFFFF_FFFF);
    send_request(CMD_MODIFY, 32'h0000_0000);
    send_request(CMD_UNKNOWN, 32'h1234_5678);
    finish_requests();
    // second way appears, old line stays in way 0
    set_split(0, 2, 0);
    send_request(CMD_LOAD, 32'h0000_0010);
    send_request(CMD_LOAD, 32'h0000_0020);
    send_request(CMD_LOAD, 32'h0000_0010);
    finish_requests();
    // wider offset: new tags are shorter, so the old lines no longer match
    write_register(REG_BLOCK_BITS, 8);
    send_request(CMD_LOAD, 32'h0000_00AB);
    send_request(CMD_MODIFY, 32'h0000_0100);
    send_request(CMD_LOAD, 32'h0000_0000);
    finish_requests();
    // set bits above max, zero ways, offset leaves no tag bits
    set_split(7, 0, 31);
    send_request(CMD_LOAD, 32'h0000_0000);
    send_request(CMD_STORE, 32'h8000_0000);
    send_request(CMD_LOAD, 32'h7FFF_FFFF);
    finish_requests();
    // too many ways, set plus offset exactly 32
    set_split(6, 15, 26);
    send_request(CMD_MODIFY, 32'hFC00_0000);
    send_request(CMD_LOAD, 32'h0400_0000);
    send_request(CMD_LOAD, 32'hFFFF_FFFF);
    send_request(CMD_UNKNOWN, 32'h0000_0000);
    send_request(CMD_STORE, 32'hFC00_0000);
    finish_requests();
  endtask

  // random traffic under one split; a small tag pool and few sets give reuse
  task automatic run_random_phase(input int set_val, input int ways_val,
                                  input int block_val, input int count);
    logic [31:0] tag_pool[MAX_WAYS+2];
    logic [31:0] addr;
    logic [31:0] tag;
    logic [31:0] set;
    logic [31:0] off;
    logic [1:0]  cmd;
    int          sb_eff;
    int          pool_n;
    int          shift;
    set_split(set_val, ways_val, block_val);
    sb_eff = (set_val > MAX_SET_BITS) ? MAX_SET_BITS : set_val;
    pool_n = ((ways_val == 0) ? 1 : ((ways_val > MAX_WAYS) ? MAX_WAYS : ways_val)) + 2;
    shift = sb_eff + block_val;
    foreach (tag_pool[k]) tag_pool[k] = $urandom;
    for (int i = 0; i < count; i++) begin
      cmd = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 99) < 12) begin
        // stray address, mostly a miss
        addr = $urandom;
      end else begin
        tag = tag_pool[$urandom_range(0, pool_n - 1)];
        set = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3);
        off = $urandom;
        addr = ((shift >= 32) ? 32'd0 : (tag << shift))
             | ((set & ((32'd1 << sb_eff) - 32'd1)) << block_val)
             | (off & ((32'd1 << block_val) - 32'd1));
      end
      send_request(cmd, addr);
    end
    finish_requests();
  endtask

  // split settings for the random part: set bits, ways, offset bits
  int plan[8][3] = '{'{0, 1, 0}, '{6, 8, 0}, '{2, 4, 4}, '{7, 15, 5},
                     '{3, 0, 31}, '{1, 3, 26}, '{4, 8, 2}, '{5, 7, 29}};

  initial begin
    sb = new();
    results_seen = 0;
    quiet_cycles = 0;
    no_idle = 1'b0;
    rst = 1'b1;
    req = '0;
    req_valid = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    foreach (plan[p]) begin
      // one phase runs back to back on both sides
      no_idle = (p == 2);
      run_random_phase(plan[p][0], plan[p][1], plan[p][2], 150);
    end
    no_idle = 1'b0;

    // settle: catch any stray result after the last expected one
    repeat (10) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
